FILE: design/pointer_motion_tracker_assert.svh
// Assertion macros used by the pointer motion tracker top level.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef POINTER_MOTION_TRACKER_ASSERT_SVH
`define POINTER_MOTION_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define PMT_ASSERT_NOW(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define PMT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

FILE: design/pmt_pkg.sv
// Types, codes and the clamp helper for the pointer motion tracker.
// Used by pmt_cfg, pmt_step and pointer_motion_tracker.
`default_nettype none

package pmt_pkg;

  typedef enum logic [2:0] {
    KIND_ROOT       = 3'd0,
    KIND_REL        = 3'd1,
    KIND_ABS        = 3'd2,
    KIND_RESET      = 3'd3,
    KIND_RESET_BASE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CFG_BOUND_X     = 3'd0,
    CFG_BOUND_Y     = 3'd1,
    CFG_WARP_ENABLE = 3'd2,
    CFG_WARP_X      = 3'd3,
    CFG_WARP_Y      = 3'd4
  } cfg_idx_t;

  // Half-width of the warp capture window: 1.0 in Q.4.
  localparam logic signed [16:0] WarpWindow = 17'sd16;

  typedef struct packed {
    logic [15:0]        bound_x;
    logic [15:0]        bound_y;
    logic               warp_enable;
    logic signed [15:0] warp_x;
    logic signed [15:0] warp_y;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] val_x;
    logic signed [15:0] val_y;
    logic signed [15:0] root_x;
    logic signed [15:0] root_y;
    logic               jump_valid;
    logic signed [15:0] jump_x;
    logic signed [15:0] jump_y;
  } item_t;

  typedef struct packed {
    logic [15:0]        cursor_x;
    logic [15:0]        cursor_y;
    logic               base_valid;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
  } trk_state_t;

  // Saturates a widened signed coordinate to [0, hi].
  function automatic logic [15:0] clamp_axis(input logic signed [18:0] v,
                                             input logic [15:0] hi);
    logic [15:0] r;
    if (v < 19'sd0) begin
      r = 16'd0;
    end else if (v > $signed({3'b000, hi})) begin
      r = hi;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/pmt_cfg.sv
// Configuration register file of the pointer motion tracker.
// Depends on pmt_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module pmt_cfg
  import pmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOUND_X:     cfg_nxt.bound_x     = cfg_wdata;
        CFG_BOUND_Y:     cfg_nxt.bound_y     = cfg_wdata;
        CFG_WARP_ENABLE: cfg_nxt.warp_enable = cfg_wdata[0];
        CFG_WARP_X:      cfg_nxt.warp_x      = $signed(cfg_wdata);
        CFG_WARP_Y:      cfg_nxt.warp_y      = $signed(cfg_wdata);
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: design/pmt_step.sv
// Combinational update of the tracker for one item: new cursor, baseline and report flag.
// Depends on pmt_pkg for kinds, bundles and clamp_axis.
`default_nettype none

module pmt_step
  import pmt_pkg::*;
(
  input  wire cfg_t       cfg,
  input  wire trk_state_t cur,
  input  wire item_t      item,
  output trk_state_t      nxt,
  output logic            report
);

  logic [15:0]        px, py;
  logic signed [16:0] wdx, wdy;
  logic               near_warp;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               too_far;
  logic [15:0]        mx, my;
  logic [15:0]        vcx, vcy;

  always_comb begin
    // The stored cursor is re-clamped to the present box before use.
    px = clamp_axis($signed({3'b000, cur.cursor_x}), cfg.bound_x);
    py = clamp_axis($signed({3'b000, cur.cursor_y}), cfg.bound_y);

    wdx = {item.root_x[15], item.root_x} - {cfg.warp_x[15], cfg.warp_x};
    wdy = {item.root_y[15], item.root_y} - {cfg.warp_y[15], cfg.warp_y};
    near_warp = cfg.warp_enable &&
                (wdx >= -WarpWindow) && (wdx <= WarpWindow) &&
                (wdy >= -WarpWindow) && (wdy <= WarpWindow);

    dx  = {item.root_x[15], item.root_x} - {cur.base_x[15], cur.base_x};
    dy  = {item.root_y[15], item.root_y} - {cur.base_y[15], cur.base_y};
    // The most negative difference negates to itself, which read unsigned is correct.
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    too_far = ({adx, 2'b00} > {3'b000, cfg.bound_x}) ||
              ({ady, 2'b00} > {3'b000, cfg.bound_y});

    mx = clamp_axis($signed({3'b000, px}) + $signed({{2{dx[16]}}, dx}), cfg.bound_x);
    my = clamp_axis($signed({3'b000, py}) + $signed({{2{dy[16]}}, dy}), cfg.bound_y);

    vcx = clamp_axis($signed({{3{item.val_x[15]}}, item.val_x}), cfg.bound_x);
    vcy = clamp_axis($signed({{3{item.val_y[15]}}, item.val_y}), cfg.bound_y);

    nxt          = cur;
    nxt.cursor_x = px;
    nxt.cursor_y = py;
    report       = 1'b0;

    unique case (item.kind)
      KIND_ROOT: begin
        if (near_warp) begin
          nxt.base_x     = cfg.warp_x;
          nxt.base_y     = cfg.warp_y;
          nxt.base_valid = 1'b1;
        end else if (!cur.base_valid) begin
          nxt.base_x     = item.root_x;
          nxt.base_y     = item.root_y;
          nxt.base_valid = 1'b1;
        end else begin
          nxt.base_x = item.root_x;
          nxt.base_y = item.root_y;
          if (too_far) begin
            if (item.jump_valid) begin
              nxt.cursor_x = clamp_axis($signed({{3{item.jump_x[15]}}, item.jump_x}),
                                        cfg.bound_x);
              nxt.cursor_y = clamp_axis($signed({{3{item.jump_y[15]}}, item.jump_y}),
                                        cfg.bound_y);
            end
          end else begin
            nxt.cursor_x = mx;
            nxt.cursor_y = my;
          end
          report = (nxt.cursor_x != px) || (nxt.cursor_y != py);
        end
      end
      KIND_REL: begin
        nxt.cursor_x = clamp_axis($signed({3'b000, px}) +
                                  $signed({{3{item.val_x[15]}}, item.val_x}), cfg.bound_x);
        nxt.cursor_y = clamp_axis($signed({3'b000, py}) +
                                  $signed({{3{item.val_y[15]}}, item.val_y}), cfg.bound_y);
        report = 1'b1;
      end
      KIND_ABS: begin
        nxt.cursor_x = vcx;
        nxt.cursor_y = vcy;
        report       = 1'b1;
      end
      KIND_RESET: begin
        nxt.cursor_x   = vcx;
        nxt.cursor_y   = vcy;
        nxt.base_valid = 1'b0;
      end
      KIND_RESET_BASE: begin
        nxt.cursor_x   = vcx;
        nxt.cursor_y   = vcy;
        nxt.base_x     = item.root_x;
        nxt.base_y     = item.root_y;
        nxt.base_valid = 1'b1;
      end
      default: begin
        nxt    = cur;
        report = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/pointer_motion_tracker.sv
// Top level of the pointer motion tracker: input register, tracker state, result register.
// Depends on pmt_pkg, pmt_cfg, pmt_step and pointer_motion_tracker_assert.svh.
//
//   Port group | Direction | Handshake         | Payload
//   in_*       | into      | in_valid/in_stall | kind, val, root, jump fields
//   out_*      | out of    | out_valid/out_stall| cursor_x, cursor_y
//   cfg_*      | into      | cfg_we            | cfg_index, cfg_wdata
//
// One item per cycle is accepted while in_stall is low; an accepted item is held in the input
// register, and its result, if it gives one, is then loaded into the result register.
// The whole update is combinational between the input register and the result register.
// A transfer that gives no result clears out_valid and leaves the result values untouched.
// out_stall on a waiting result holds it; if an item is held, that stays too and in_stall rises.
// Synchronous reset clears the configuration, cursor and baseline; no clearing pass.
`default_nettype none

module pointer_motion_tracker
  import pmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic signed [15:0] in_val_x,
  input  wire logic signed [15:0] in_val_y,
  input  wire logic signed [15:0] in_root_x,
  input  wire logic signed [15:0] in_root_y,
  input  wire logic        in_jump_valid,
  input  wire logic signed [15:0] in_jump_x,
  input  wire logic signed [15:0] in_jump_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_cursor_x,
  output logic [15:0]      out_cursor_y,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t       cfg;
  item_t      item_r;
  logic       item_valid_r;
  trk_state_t trk_r;
  trk_state_t trk_nxt;
  logic       report;
  logic       advance;
  logic       out_valid_r;
  logic [15:0] out_x_r, out_y_r;

  pmt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pmt_step u_step (
    .cfg    (cfg),
    .cur    (trk_r),
    .item   (item_r),
    .nxt    (trk_nxt),
    .report (report)
  );

  // The held item moves on whenever the result register is free or being drained.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.kind       <= in_kind;
      item_r.val_x      <= in_val_x;
      item_r.val_y      <= in_val_y;
      item_r.root_x     <= in_root_x;
      item_r.root_y     <= in_root_y;
      item_r.jump_valid <= in_jump_valid;
      item_r.jump_x     <= in_jump_x;
      item_r.jump_y     <= in_jump_y;
    end
  end

  // A new bound pulls the stored cursor inside the box at once, unless an item advances then.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r <= '0;
    end else if (item_valid_r && advance) begin
      trk_r <= trk_nxt;
    end else if (cfg_we && (cfg_index == CFG_BOUND_X)) begin
      trk_r.cursor_x <= clamp_axis($signed({3'b000, trk_r.cursor_x}), cfg_wdata);
    end else if (cfg_we && (cfg_index == CFG_BOUND_Y)) begin
      trk_r.cursor_y <= clamp_axis($signed({3'b000, trk_r.cursor_y}), cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r && report;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r && report) begin
      out_x_r <= trk_nxt.cursor_x;
      out_y_r <= trk_nxt.cursor_y;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cursor_x = out_x_r;
  assign out_cursor_y = out_y_r;

`include "pointer_motion_tracker_assert.svh"

  `PMT_ASSERT_NOW(a_stall_needs_item, in_stall, item_valid_r && out_valid_r, "stall without a held item")
  `PMT_ASSERT_NEXT(a_held_item_kept, item_valid_r && !advance, item_valid_r, "held item lost during stall")
  `PMT_ASSERT_NEXT(a_rel_reports, item_valid_r && advance && (item_r.kind == KIND_REL), out_valid_r, "relative item gave no result")
  `PMT_ASSERT_NEXT(a_reset_clears_base, item_valid_r && advance && (item_r.kind == KIND_RESET), !trk_r.base_valid, "reset item left a baseline")
  `PMT_ASSERT_NEXT(a_root_sets_base, item_valid_r && advance && (item_r.kind == KIND_ROOT), trk_r.base_valid, "root motion left no baseline")

endmodule

`default_nettype wire
